// ===== rtl/core/cdt_pkg.sv =====
`default_nettype none

package cdt_pkg;

	// Genetic code table geometry.
	localparam int TABLE_DEPTH     = 65;
	localparam int INDEX_W         = 7;
	localparam int MAX_ENTRY_CHARS = 3;
	localparam int CHAR_W          = 8;
	localparam int LEN_W           = 2;
	localparam int CHARS_W         = MAX_ENTRY_CHARS * CHAR_W;

	// Index of the ambiguous entry, used when a codon holds a non-nucleotide.
	localparam logic [INDEX_W-1:0] AMBIG_INDEX = INDEX_W'(64);

	// Item kinds carried on the input tuser bit.
	localparam logic MODE_NUC   = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	// Stream widths, padded to whole bytes.
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 16;

	// One table entry: length above the characters, first character highest.
	typedef struct packed {
		logic [LEN_W-1:0]   len;
		logic [CHARS_W-1:0] chars;
	} entry_t;

	// Write request into the table memory.
	typedef struct packed {
		logic               en;
		logic [INDEX_W-1:0] addr;
		entry_t             data;
	} tbl_wr_t;

	// Read request into the table memory.
	typedef struct packed {
		logic               en;
		logic [INDEX_W-1:0] addr;
	} tbl_rd_t;

endpackage

`default_nettype wire

// ===== rtl/core/codon_translator.sv =====
// Channel  Direction  tdata                                               tuser  tlast
// s_axis   in         nucleotide, entry_index, entry_length, entry_chars  mode   end_of_sequence
// m_axis   out        amino_char, codon_index                             -      last_of_codon
//
// One input item is taken every cycle while the entry queue has room; a table
// write uses the table write port and a codon lookup its read port.
// A completed codon passes through the table read register and the entry queue into
// the output register; its characters leave one per cycle while m_axis_tready is high.
// Reset clears the codon state, the entry queue and the output register; the
// table memory itself is not cleared. A stalled output backs up into the
// four-entry queue, and s_axis_tready drops once the queue could overflow.
`default_nettype none

module codon_translator import cdt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// [7:0] nucleotide, [14:8] entry_index, [16:15] entry_length, [40:17] entry_chars
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  wire logic                  s_axis_tlast,
	// [0] mode
	input  wire logic                  s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [7:0] amino_char, [14:8] codon_index
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                       m_axis_tlast
);

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int COUNT_W    = $clog2(FIFO_DEPTH + 1);

	// Maps a character to its base value, 4 for anything but a nucleotide.
	function automatic logic [2:0] base_value(input logic [CHAR_W-1:0] ch);
		logic [2:0] v;
		unique case (ch)
			"A", "a":           v = 3'd0;
			"C", "c":           v = 3'd1;
			"G", "g":           v = 3'd2;
			"T", "t", "U", "u": v = 3'd3;
			default:            v = 3'd4;
		endcase
		return v;
	endfunction

	logic                 in_acc;
	logic [CHAR_W-1:0]    in_nuc;
	logic [INDEX_W-1:0]   in_widx;
	logic [LEN_W-1:0]     in_wlen;
	logic [CHARS_W-1:0]   in_wchars;

	logic [1:0]           phase_q;
	logic [5:0]           part_q;
	logic                 inv_q;
	logic [1:0]           phase_n;
	logic [5:0]           part_n;
	logic                 inv_n;
	logic [5:0]           part_upd;
	logic                 inv_upd;
	logic [2:0]           base_v;
	logic                 nuc_acc;
	logic                 complete;
	logic [INDEX_W-1:0]   lookup_idx;

	tbl_wr_t              tbl_wr;
	tbl_rd_t              tbl_rd;
	entry_t               tbl_rdata;

	logic                 lookup_s1;
	logic [INDEX_W-1:0]   idx_s1;

	entry_t               fifo_ent_q [FIFO_DEPTH];
	logic [INDEX_W-1:0]   fifo_idx_q [FIFO_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [COUNT_W-1:0]   count_q;
	logic [1:0]           char_q;
	logic                 push;
	logic                 pop;
	logic                 out_load;
	logic                 head_last;
	entry_t               head_ent;
	logic [CHAR_W-1:0]    head_char;

	logic                 out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                 out_last_q;

	// Unpack the input item.
	assign in_acc    = s_axis_tvalid & s_axis_tready;
	assign in_nuc    = s_axis_tdata[7:0];
	assign in_widx   = s_axis_tdata[14:8];
	assign in_wlen   = s_axis_tdata[16:15];
	assign in_wchars = s_axis_tdata[40:17];

	// Codon assembly: fold the new base into the partial index.
	always_comb begin
		nuc_acc  = in_acc & (s_axis_tuser == MODE_NUC);
		base_v   = base_value(in_nuc);
		inv_upd  = inv_q | base_v[2];
		part_upd = base_v[2] ? part_q : {part_q[3:0], base_v[1:0]};
		complete = nuc_acc & (phase_q == 2'd2);
		lookup_idx = inv_upd ? AMBIG_INDEX : {1'b0, part_upd};
		phase_n  = phase_q;
		part_n   = part_q;
		inv_n    = inv_q;
		if (nuc_acc) begin
			if (complete || s_axis_tlast) begin
				phase_n = 2'd0;
				part_n  = 6'd0;
				inv_n   = 1'b0;
			end else begin
				phase_n = phase_q + 2'd1;
				part_n  = part_upd;
				inv_n   = inv_upd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			part_q  <= 6'd0;
			inv_q   <= 1'b0;
		end else begin
			phase_q <= phase_n;
			part_q  <= part_n;
			inv_q   <= inv_n;
		end
	end

	// Table access. Writes and lookups come from one item stream, so they never
	// share a cycle, and a lookup right after a write reads the new entry.
	always_comb begin
		tbl_wr.en        = in_acc & (s_axis_tuser == MODE_WRITE) & (in_widx <= AMBIG_INDEX);
		tbl_wr.addr      = in_widx;
		tbl_wr.data.len  = (32'(in_wlen) > MAX_ENTRY_CHARS) ? LEN_W'(MAX_ENTRY_CHARS) : in_wlen;
		tbl_wr.data.chars = in_wchars;
		tbl_rd.en        = complete;
		tbl_rd.addr      = lookup_idx;
	end

	cdt_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd      (tbl_rd),
		.rd_data (tbl_rdata)
	);

	// Lookup in flight while the memory read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookup_s1 <= 1'b0;
		end else begin
			lookup_s1 <= complete;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= lookup_idx;
	end

	// Entry queue control and character serializer.
	always_comb begin
		push      = lookup_s1 & (tbl_rdata.len != '0);
		head_ent  = fifo_ent_q[rd_ptr_q];
		head_last = ((char_q + 2'd1) == head_ent.len);
		out_load  = (!out_valid_q || m_axis_tready) && (count_q != '0);
		pop       = out_load & head_last;
		unique case (char_q)
			2'd0:    head_char = head_ent.chars[23:16];
			2'd1:    head_char = head_ent.chars[15:8];
			default: head_char = head_ent.chars[7:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_ent_q[wr_ptr_q] <= tbl_rdata;
			fifo_idx_q[wr_ptr_q] <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			char_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + COUNT_W'(push) - COUNT_W'(pop);
			if (out_load) begin
				char_q <= head_last ? 2'd0 : char_q + 2'd1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {1'b0, fifo_idx_q[rd_ptr_q], head_char};
			out_last_q <= head_last;
		end
	end

	// Room for the lookup in flight plus one more.
	assign s_axis_tready = (count_q + COUNT_W'(lookup_s1)) < COUNT_W'(FIFO_DEPTH);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/cdt_table.sv =====
`default_nettype none

module cdt_table import cdt_pkg::*; (
	input  wire logic    clk,
	input  wire tbl_wr_t wr,
	input  wire tbl_rd_t rd,
	output entry_t       rd_data
);

	// Genetic code table, one entry per codon plus the ambiguous entry.
	entry_t mem [TABLE_DEPTH];

	// Single write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cdt_checker.sv =====
`default_nettype none

module cdt_checker import cdt_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input wire logic                  s_axis_tlast,
	input wire logic                  s_axis_tuser,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic                  m_axis_tlast
);

	// An offered input item holds until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
		s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast) &&
		$stable(s_axis_tuser))
		else $error("input item changed while stalled");

	// A stalled result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// Nothing is offered on the first edge after reset.
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_axis_tvalid)
		else $error("result offered right after reset");

	// The looked-up index never exceeds the ambiguous entry.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[14:8] <= AMBIG_INDEX)
		else $error("codon index out of range");

	// Characters of one codon carry the same index.
	a_codon_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
		!m_axis_tvalid || (m_axis_tdata[14:8] == $past(m_axis_tdata[14:8])))
		else $error("codon index changed within a codon");

endmodule

bind codon_translator cdt_checker u_cdt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== verif/codon_translator_tb.sv =====
`default_nettype none

module codon_translator_tb import cdt_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// Code returned for a character that is not a nucleotide.
	localparam logic [2:0] NOT_A_BASE = 3'd4;
	// Cycles allowed after the last expected character for stray output.
	localparam int DRAIN_CYCLES = 20;

	// One emitted amino-acid character.
	typedef struct packed {
		logic [CHAR_W-1:0]  amino_char;
		logic [INDEX_W-1:0] codon_index;
		logic               last_of_codon;
	} amino_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic s_axis_tlast;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	// Translator state as the testbench sees it.
	int            codon_phase;
	logic [5:0]    partial_index;
	logic          invalid_seen;
	entry_t        code_table [TABLE_DEPTH];
	amino_result_t expected_aminos [$];

	int  fail_count     = 0;
	int  accepted_items = 0;
	bit  idling         = 1'b1;

	codon_translator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	// Maps a character to its base value, or to NOT_A_BASE.
	function automatic logic [2:0] base_code(input logic [7:0] ch);
		case (ch)
			"A", "a": return 3'd0;
			"C", "c": return 3'd1;
			"G", "g": return 3'd2;
			"T", "t", "U", "u": return 3'd3;
			default: return NOT_A_BASE;
		endcase
	endfunction

	function automatic void clear_codon();
		codon_phase   = 0;
		partial_index = '0;
		invalid_seen  = 1'b0;
	endfunction

	// Updates the tracked state for one accepted item and queues the characters it emits.
	function automatic void translate_item(input logic mode, input logic [7:0] nuc,
			input logic eos, input logic [INDEX_W-1:0] wr_index,
			input logic [LEN_W-1:0] wr_len, input logic [CHARS_W-1:0] wr_chars);
		logic [2:0]         code;
		logic [INDEX_W-1:0] lookup;
		entry_t             entry;
		int                 k;
		if (mode == MODE_WRITE) begin
			if (wr_index < TABLE_DEPTH) begin
				code_table[wr_index] = '{len: wr_len, chars: wr_chars};
			end
			return;
		end
		code = base_code(nuc);
		if (code == NOT_A_BASE) begin
			invalid_seen = 1'b1;
		end else begin
			partial_index = {partial_index[3:0], code[1:0]};
		end
		codon_phase++;
		if (codon_phase == 3) begin
			lookup = invalid_seen ? AMBIG_INDEX : {1'b0, partial_index};
			entry  = code_table[lookup];
			for (k = 0; k < entry.len; k++) begin
				expected_aminos.push_back('{
					amino_char:    entry.chars[CHARS_W-1-CHAR_W*k -: CHAR_W],
					codon_index:   lookup,
					last_of_codon: (k == entry.len - 1)});
			end
			clear_codon();
		end
		if (eos) begin
			clear_codon();
		end
	endfunction

	// Sends one item; entered and left at a falling edge.
	task automatic send_item(input logic mode, input logic [7:0] nuc, input logic eos,
			input logic [INDEX_W-1:0] wr_index, input logic [LEN_W-1:0] wr_len,
			input logic [CHARS_W-1:0] wr_chars);
		int gap;
		if (idling && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tlast  <= eos;
		s_axis_tdata  <= {7'b0, wr_chars, wr_len, wr_index, nuc};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		translate_item(mode, nuc, eos, wr_index, wr_len, wr_chars);
		accepted_items++;
		@(negedge clk);
	endtask

	task automatic send_nuc(input logic [7:0] ch, input logic eos);
		send_item(MODE_NUC, ch, eos, INDEX_W'($urandom), LEN_W'($urandom), CHARS_W'($urandom));
	endtask

	task automatic send_entry(input logic [INDEX_W-1:0] wr_index, input logic [LEN_W-1:0] wr_len,
			input logic [CHARS_W-1:0] wr_chars, input logic eos = 1'b0);
		send_item(MODE_WRITE, 8'($urandom), eos, wr_index, wr_len, wr_chars);
	endtask

	function automatic logic [7:0] random_base();
		string bases;
		bases = "ACGTUacgtu";
		return bases[$urandom_range(0, 9)];
	endfunction

	// Every entry is loaded before any lookup, so no codon reads an unwritten entry.
	task automatic test_table_load();
		int i;
		for (i = 0; i < TABLE_DEPTH; i++) begin
			send_entry(INDEX_W'(i), LEN_W'(i), CHARS_W'($urandom));
		end
	endtask

	// Extremes of the fields and each corner of codon handling.
	task automatic test_directed();
		send_entry(7'd63, 2'd3, "XYZ");
		send_entry(7'd0, 2'd0, 24'hABCDEF);
		send_entry(AMBIG_INDEX, 2'd3, 24'hFFFFFF);
		// Out-of-range writes must not land on any entry.
		send_entry(7'd127, 2'd1, 24'h000000);
		send_entry(7'd65, 2'd2, 24'h123456);
		// Codon whose entry is empty.
		send_nuc("A", 1'b0); send_nuc("A", 1'b0); send_nuc("A", 1'b0);
		// Last codon index, with the end mark on its third character.
		send_nuc("t", 1'b0); send_nuc("t", 1'b0); send_nuc("U", 1'b1);
		// A zero byte makes the codon ambiguous.
		send_nuc("A", 1'b0); send_nuc(8'h00, 1'b0); send_nuc("C", 1'b0);
		// Partial codons dropped by the end mark, then a codon made ambiguous by an 8'hFF byte.
		send_nuc("G", 1'b1);
		send_nuc("C", 1'b0); send_nuc("g", 1'b1);
		send_nuc(8'hFF, 1'b0); send_nuc("a", 1'b0); send_nuc("a", 1'b0);
		// A table write in the middle of a codon leaves its state alone.
		send_nuc("A", 1'b0);
		send_entry(7'd6, 2'd2, "LV?", 1'b1);
		send_nuc("c", 1'b0); send_nuc("G", 1'b0);
	endtask

	// Mostly well-formed codons, some with noise, some cut short, and table rewrites.
	task automatic send_random_unit();
		int pick, bad_pos, n_chars, k;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			if (pick < 2) begin
				send_entry(INDEX_W'($urandom_range(65, 127)), LEN_W'($urandom),
					CHARS_W'($urandom));
			end else begin
				send_entry(INDEX_W'($urandom_range(0, 64)), LEN_W'($urandom),
					CHARS_W'($urandom));
			end
		end else if (pick < 16) begin
			n_chars = $urandom_range(1, 2);
			for (k = 0; k < n_chars; k++) begin
				send_nuc(random_base(), k == n_chars - 1);
			end
		end else begin
			bad_pos = (pick < 30) ? $urandom_range(0, 2) : -1;
			for (k = 0; k < 3; k++) begin
				send_nuc((k == bad_pos) ? 8'($urandom) : random_base(),
					k == 2 && $urandom_range(0, 7) == 0);
			end
		end
	endtask

	task automatic test_random_sequences(input int n_items);
		int target;
		target = accepted_items + n_items;
		while (accepted_items < target) send_random_unit();
	endtask

	// Full rate on both sides.
	task automatic test_back_to_back(input int n_items);
		int target;
		idling = 1'b0;
		target = accepted_items + n_items;
		while (accepted_items < target) send_random_unit();
	endtask

	// Output side pacing: ready bursts and stall bursts.
	initial begin : sink_pacing
		int span;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idling && $urandom_range(0, 2) == 0) begin
				span = $urandom_range(1, 8);
				m_axis_tready <= 1'b0;
			end else begin
				span = $urandom_range(1, 12);
				m_axis_tready <= 1'b1;
			end
			repeat (span - 1) @(negedge clk);
		end
	end

	// Compares each accepted output item with the oldest expected character.
	always @(posedge clk) begin : result_check
		amino_result_t want;
		if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			if (expected_aminos.size() == 0) begin
				$error("unexpected output item: amino_char %h codon_index %0d",
					m_axis_tdata[7:0], m_axis_tdata[14:8]);
				fail_count++;
			end else begin
				want = expected_aminos.pop_front();
				if (m_axis_tdata[7:0] !== want.amino_char) begin
					$error("amino_char: expected %h, actual %h",
						want.amino_char, m_axis_tdata[7:0]);
					fail_count++;
				end
				if (m_axis_tdata[14:8] !== want.codon_index) begin
					$error("codon_index: expected %0d, actual %0d",
						want.codon_index, m_axis_tdata[14:8]);
					fail_count++;
				end
				if (m_axis_tlast !== want.last_of_codon) begin
					$error("last_of_codon: expected %b, actual %b",
						want.last_of_codon, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	initial begin : main_sequence
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		s_axis_tuser  = MODE_NUC;
		clear_codon();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_table_load();
		test_directed();
		test_random_sequences(140);
		test_back_to_back(40);

		s_axis_tvalid <= 1'b0;
		while (expected_aminos.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("codon_translator verification clean");
		end else begin
			$display("codon_translator verification failed");
		end
		$finish;
	end

	// Ends a hung run.
	initial begin : watchdog
		#5ms;
		$display("codon_translator verification failed");
		$finish;
	end

endmodule

`default_nettype wire
